/* rtl/wtkm_pkg.sv */
// ----------------------------------------------------------------------------
// wtkm_pkg
// Shared sizes and types for the winner-tree k-way merge: leaf index, value
// and the leaf record that the compare unit works on.
// ----------------------------------------------------------------------------
package wtkm_pkg;

    // tree size and data width
    localparam int MAX_RUNS   = 16;
    localparam int VALUE_BITS = 32;
    localparam int LEAF_BITS  = $clog2(MAX_RUNS);
    localparam int CNT_BITS   = $clog2(MAX_RUNS + 1);
    localparam int CFG_BITS   = 5;
    localparam int ROWS       = MAX_RUNS / 2;
    localparam int ROW_BITS   = LEAF_BITS - 1;

    typedef logic [LEAF_BITS-1:0]         leaf_idx_t;
    typedef logic signed [VALUE_BITS-1:0] value_t;

    // one contender at a tree node
    typedef struct packed {
        logic      exhausted;
        leaf_idx_t idx;
        value_t    val;
    } leaf_t;

endpackage

/* rtl/wtkm_beats.sv */
// ----------------------------------------------------------------------------
// wtkm_beats
// Match unit of the winner tree: picks the winner of two leaves. A live run
// beats an exhausted one, then the smaller value wins, then the lower run.
// ----------------------------------------------------------------------------
module wtkm_beats (
    input  wtkm_pkg::leaf_t left_leaf,
    input  wtkm_pkg::leaf_t right_leaf,
    output wtkm_pkg::leaf_t win_leaf
);
    import wtkm_pkg::*;

    logic left_wins;

    // ordering: live first, then value, then index
    always_comb begin
        priority if (left_leaf.exhausted != right_leaf.exhausted) begin
            left_wins = !left_leaf.exhausted;
        end else if (!left_leaf.exhausted && (left_leaf.val != right_leaf.val)) begin
            left_wins = left_leaf.val < right_leaf.val;
        end else begin
            left_wins = left_leaf.idx < right_leaf.idx;
        end
    end

    assign win_leaf = left_wins ? left_leaf : right_leaf;

endmodule

/* rtl/winner_tree_kway_merge.sv */
// ----------------------------------------------------------------------------
// winner_tree_kway_merge
// Merges up to MAX_RUNS ascending runs through a winner tree with one shared
// match unit stepped over the tree nodes by a small sequencer.
// ----------------------------------------------------------------------------
// Sequencing: every tree node takes a read step, which reads both
// contenders' values from the registered leaf memory, and a compare step in
// the single match unit. A run head that is not the last is written
// straight into its slot. The last load builds the whole tree, nodes
// MAX_RUNS-1 down to the root, and a refill replays one leaf-to-root path;
// the root compare is followed by a load of the output register, after
// which the next word can be taken. That load waits only while an older
// result still holds the output register. s_ready is low while the tree is
// being worked on. The output register lets the next word be taken while a
// result still waits on m_ready. There is no clearing pass after reset.
// s_run_index is not used: the slot comes from the load count while loading
// and from the current winner while merging.
module winner_tree_kway_merge (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       cfg_we,
    input  logic [wtkm_pkg::CFG_BITS-1:0] cfg_wdata,
    // input words
    input  logic                       s_valid,
    output logic                       s_ready,
    input  wtkm_pkg::leaf_idx_t        s_run_index,
    input  wtkm_pkg::value_t           s_value,
    input  logic                       s_run_exhausted,
    // result words
    output logic                       m_valid,
    input  logic                       m_ready,
    output wtkm_pkg::value_t           m_winner_value,
    output wtkm_pkg::leaf_idx_t        m_winner_run,
    output logic                       m_merge_done
);
    import wtkm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_CMP  = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [CFG_BITS-1:0]   num_reg, num_next;
    logic [CNT_BITS-1:0]   lc_reg, lc_next;
    logic [CNT_BITS-1:0]   rr_reg, rr_next;
    logic                  merging_reg, merging_next;
    logic                  replay_reg, replay_next;
    leaf_idx_t             node_reg, node_next;
    logic [MAX_RUNS-1:0]   exh_reg, exh_next;

    // leaf value memory and node winners (two per row: nodes 2q and 2q+1)
    value_t                leaf_mem [MAX_RUNS];
    logic [1:0][LEAF_BITS-1:0] nw_reg [ROWS];

    logic                  mem_we;
    leaf_idx_t             mem_waddr;
    leaf_idx_t             rd_l, rd_r;
    leaf_idx_t             l_reg, r_reg;
    value_t                rd_a_reg, rd_b_reg;
    value_t                win_val_reg;
    leaf_idx_t             root;
    logic [CNT_BITS-1:0]   n_act;
    logic                  emit_fire;
    logic                  m_valid_reg;
    value_t                m_value_reg;
    leaf_idx_t             m_run_reg;
    logic                  m_done_reg;
    leaf_t                 cmp_l, cmp_r, cmp_win;

    assign root = nw_reg[0][1];

    // effective run count: zero acts as one, clipped at the tree size
    always_comb begin
        if (num_reg == '0) begin
            n_act = CNT_BITS'(1);
        end else if (num_reg > CFG_BITS'(MAX_RUNS)) begin
            n_act = CNT_BITS'(MAX_RUNS);
        end else begin
            n_act = CNT_BITS'(num_reg);
        end
    end

    // children of the current node: leaves at the bottom level, else winners
    always_comb begin
        if (node_reg[LEAF_BITS-1]) begin
            rd_l = {node_reg[ROW_BITS-1:0], 1'b0};
            rd_r = {node_reg[ROW_BITS-1:0], 1'b1};
        end else begin
            rd_l = nw_reg[node_reg[ROW_BITS-1:0]][0];
            rd_r = nw_reg[node_reg[ROW_BITS-1:0]][1];
        end
    end

    // shared match unit
    assign cmp_l = '{exhausted: exh_reg[l_reg], idx: l_reg, val: rd_a_reg};
    assign cmp_r = '{exhausted: exh_reg[r_reg], idx: r_reg, val: rd_b_reg};

    wtkm_beats u_beats (
        .left_leaf  (cmp_l),
        .right_leaf (cmp_r),
        .win_leaf   (cmp_win)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign emit_fire = (state_reg == S_EMIT) && (!m_valid_reg || m_ready);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        num_next     = num_reg;
        lc_next      = lc_reg;
        rr_next      = rr_reg;
        merging_next = merging_reg;
        replay_next  = replay_reg;
        node_next    = node_reg;
        exh_next     = exh_reg;
        mem_we       = 1'b0;
        mem_waddr    = root;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (!merging_reg) begin
                        // loading: next run head goes into the slot of the load count
                        if (lc_reg < n_act) begin
                            mem_we    = 1'b1;
                            mem_waddr = lc_reg[LEAF_BITS-1:0];
                            exh_next[lc_reg[LEAF_BITS-1:0]] = s_run_exhausted;
                            if (!s_run_exhausted) begin
                                rr_next = rr_reg + CNT_BITS'(1);
                            end
                            lc_next = lc_reg + CNT_BITS'(1);
                        end
                        if (lc_next >= n_act) begin
                            for (int i = 0; i < MAX_RUNS; i++) begin
                                if (CNT_BITS'(i) >= n_act) begin
                                    exh_next[i] = 1'b1;
                                end
                            end
                            node_next    = LEAF_BITS'(MAX_RUNS - 1);
                            replay_next  = 1'b0;
                            merging_next = 1'b1;
                            state_next   = S_READ;
                        end
                    end else begin
                        // merging: refill or retire the run that last won
                        if (s_run_exhausted) begin
                            if (!exh_reg[root] && (rr_reg != '0)) begin
                                rr_next = rr_reg - CNT_BITS'(1);
                            end
                            exh_next[root] = 1'b1;
                        end else begin
                            mem_we = 1'b1;
                        end
                        node_next   = {1'b1, root[LEAF_BITS-1:1]};
                        replay_next = 1'b1;
                        state_next  = S_READ;
                    end
                end
            end
            S_READ: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                if (node_reg == LEAF_BITS'(1)) begin
                    state_next = S_EMIT;
                end else begin
                    node_next  = replay_reg ? (node_reg >> 1) : (node_reg - LEAF_BITS'(1));
                    state_next = S_READ;
                end
            end
            S_EMIT: begin
                if (emit_fire) begin
                    state_next = S_IDLE;
                    if (rr_reg == '0) begin
                        exh_next     = '0;
                        lc_next      = '0;
                        merging_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        // a register write drops any merge in progress
        if (cfg_we) begin
            num_next     = cfg_wdata;
            exh_next     = '0;
            lc_next      = '0;
            rr_next      = '0;
            merging_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            num_reg     <= CFG_BITS'(MAX_RUNS);
            lc_reg      <= '0;
            rr_reg      <= '0;
            merging_reg <= 1'b0;
            replay_reg  <= 1'b0;
            node_reg    <= '0;
            exh_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            num_reg     <= num_next;
            lc_reg      <= lc_next;
            rr_reg      <= rr_next;
            merging_reg <= merging_next;
            replay_reg  <= replay_next;
            node_reg    <= node_next;
            exh_reg     <= exh_next;
        end
    end

    // leaf value memory: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            leaf_mem[mem_waddr] <= s_value;
        end
        if (state_reg == S_READ) begin
            rd_a_reg <= leaf_mem[rd_l];
            rd_b_reg <= leaf_mem[rd_r];
            l_reg    <= rd_l;
            r_reg    <= rd_r;
        end
    end

    // node winner store and running winner value
    always_ff @(posedge aclk) begin
        if (state_reg == S_CMP) begin
            nw_reg[node_reg[LEAF_BITS-1:1]][node_reg[0]] <= cmp_win.idx;
            win_val_reg <= cmp_win.val;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            m_done_reg  <= (rr_reg == '0);
            m_value_reg <= (rr_reg == '0) ? '0 : win_val_reg;
            m_run_reg   <= (rr_reg == '0) ? '0 : root;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_winner_value = m_value_reg;
    assign m_winner_run   = m_run_reg;
    assign m_merge_done   = m_done_reg;

`ifndef NO_ASSERTIONS
    // live run count can never pass the number of runs loaded
    a_rr_le_lc: assert property (@(posedge aclk) disable iff (!aresetn)
        rr_reg <= lc_reg)
        else $error("live run count above loaded count");

    // a done word carries zero winner fields
    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_done_reg) |-> (m_value_reg == '0 && m_run_reg == '0))
        else $error("done word with non-zero winner fields");

    // after a done word the block is back to loading with nothing loaded
    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_fire && (rr_reg == '0)) |=> (!merging_reg && lc_reg == '0))
        else $error("merge state not cleared after done");
`endif

endmodule

/* tb/sv/winner_tree_kway_merge_tb.sv */
// ----------------------------------------------------------------------------
// winner_tree_kway_merge_tb
// Self-checking bench for the winner-tree k-way merge. A small ledger class
// tracks run heads, the live-run count and the load/merge phase, predicts the
// winner word for the last load and each word taken while merging, and checks
// the result words in order. Stimulus is a directed opening followed by random
// well-formed merges (ascending runs refilled from the predicted winner) mixed
// with noise words, under several run counts (out-of-range ones too) and aborts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import wtkm_pkg::*;

// one predicted result word
typedef struct packed {
    value_t    val;
    leaf_idx_t run;
    logic      done;
} winner_word_t;

class winner_ledger;

    value_t         head_val [MAX_RUNS];
    bit             head_ex  [MAX_RUNS];
    int unsigned    loaded;
    int unsigned    live;
    bit             merging;
    int unsigned    runs_cfg;
    winner_word_t   winners_due [$];
    int unsigned    mismatches;

    function new();
        foreach (head_val[i]) head_val[i] = '0;
        runs_cfg   = MAX_RUNS;
        mismatches = 0;
        restart();
    endfunction

    // back to loading with every run unloaded
    function void restart();
        foreach (head_ex[i]) head_ex[i] = 1'b0;
        loaded  = 0;
        live    = 0;
        merging = 1'b0;
    endfunction

    // effective run count after clamping
    function int unsigned span();
        if (runs_cfg == 0) return 1;
        if (runs_cfg > MAX_RUNS) return MAX_RUNS;
        return runs_cfg;
    endfunction

    function bit gone(int i);
        return head_ex[i] || (i >= int'(span()));
    endfunction

    // live beats exhausted, then smaller value, then lower run
    function bit outranks(int a, int b);
        if (gone(a) != gone(b)) return !gone(a);
        if (!gone(a) && head_val[a] != head_val[b]) return head_val[a] < head_val[b];
        return a < b;
    endfunction

    function leaf_idx_t leader();
        int best;
        best = 0;
        for (int i = 1; i < MAX_RUNS; i++)
            if (outranks(i, best)) best = i;
        return leaf_idx_t'(best);
    endfunction

    // slot the next word lands in
    function leaf_idx_t next_slot();
        if (merging) return leader();
        return leaf_idx_t'(loaded);
    endfunction

    function int unsigned pending();
        return winners_due.size();
    endfunction

    // any register write drops the merge in progress
    function void set_runs(int unsigned n);
        runs_cfg = n;
        restart();
    endfunction

    function void post_winner();
        winner_word_t w;
        leaf_idx_t    lead;
        if (live == 0) begin
            w = '{val: '0, run: '0, done: 1'b1};
            restart();
        end else begin
            lead = leader();
            w = '{val: head_val[lead], run: lead, done: 1'b0};
        end
        winners_due.push_back(w);
    endfunction

    // accepted input word
    function void take_head(value_t v, bit ex);
        leaf_idx_t lead;
        if (!merging) begin
            if (loaded < span()) begin
                head_val[loaded] = v;
                head_ex[loaded]  = ex;
                if (!ex) live++;
                loaded++;
            end
            if (loaded >= span()) begin
                merging = 1'b1;
                post_winner();
            end
        end else begin
            lead = leader();
            if (ex) begin
                if (!head_ex[lead] && live > 0) live--;
                head_ex[lead] = 1'b1;
            end else begin
                head_val[lead] = v;
            end
            post_winner();
        end
    endfunction

    // accepted result word against the oldest prediction
    function void match_word(value_t v, leaf_idx_t r, logic d);
        winner_word_t want;
        if (winners_due.size() == 0) begin
            $display("%0t: unexpected result word: value %0d run %0d done %0b",
                     $time, v, r, d);
            mismatches++;
        end else begin
            want = winners_due.pop_front();
            if (d !== want.done) begin
                $display("%0t: merge_done mismatch: expected %0b, got %0b",
                         $time, want.done, d);
                mismatches++;
            end
            if (v !== want.val) begin
                $display("%0t: winner_value mismatch: expected %0d, got %0d",
                         $time, want.val, v);
                mismatches++;
            end
            if (r !== want.run) begin
                $display("%0t: winner_run mismatch: expected %0d, got %0d",
                         $time, want.run, r);
                mismatches++;
            end
        end
    endfunction

endclass

module winner_tree_kway_merge_tb;

    localparam int          HALF_PERIOD   = 6;
    localparam int unsigned SETTLE_CYCLES = 48;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned RANDOM_WORDS  = 1000;
    localparam value_t      VAL_MAX       = 32'sh7fffffff;
    localparam value_t      VAL_MIN       = 32'sh80000000;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_we;
    logic [CFG_BITS-1:0] cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    leaf_idx_t           s_run_index;
    value_t              s_value;
    logic                s_run_exhausted;
    logic                m_valid;
    logic                m_ready;
    value_t              m_winner_value;
    leaf_idx_t           m_winner_run;
    logic                m_merge_done;

    winner_ledger        ledger;
    bit                  calm;
    int unsigned         quiet_cycles = 0;
    int unsigned         run_left [MAX_RUNS];
    value_t              run_tail [MAX_RUNS];

    always #HALF_PERIOD aclk = ~aclk;

    winner_tree_kway_merge dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_run_index     (s_run_index),
        .s_value         (s_value),
        .s_run_exhausted (s_run_exhausted),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_winner_value  (m_winner_value),
        .m_winner_run    (m_winner_run),
        .m_merge_done    (m_merge_done)
    );

    // mostly short gaps, a few long ones, none while calm
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_runs();
        case ($urandom_range(0, 7))
            0: return CFG_BITS'(0);
            1: return CFG_BITS'(1);
            2: return CFG_BITS'(MAX_RUNS);
            3: return CFG_BITS'(31);
            4: return CFG_BITS'(MAX_RUNS + 1);
            default: return CFG_BITS'($urandom_range(2, MAX_RUNS));
        endcase
    endfunction

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r < 8) return $urandom_range(1, 4);
        return $urandom_range(5, 12);
    endfunction

    // run head: full range, small with ties, or near either end
    function automatic value_t pick_head();
        case ($urandom_range(0, 5))
            2: return value_t'($urandom_range(0, 15)) - 8;
            3: return VAL_MAX - value_t'($urandom_range(0, 3));
            4: return VAL_MIN + value_t'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    // next element of an ascending run, saturating at the top
    function automatic value_t climb(value_t prev);
        longint nxt;
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5)
            nxt = longint'(prev) + longint'($urandom_range(0, 2));
        else if (r < 8)
            nxt = longint'(prev) + longint'($urandom_range(0, 1000));
        else
            nxt = longint'(prev) + longint'($urandom_range(0, 32'h3fffffff));
        if (nxt > longint'(VAL_MAX)) nxt = longint'(VAL_MAX);
        return value_t'(nxt);
    endfunction

    // present one word at a falling edge, hold until taken, then maybe idle
    task automatic send_word(input leaf_idx_t ri, input value_t v, input logic ex);
        int unsigned gap;
        s_valid         <= 1'b1;
        s_run_index     <= ri;
        s_value         <= v;
        s_run_exhausted <= ex;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ledger.take_head(v, ex);
        @(negedge aclk);
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic push_head(input value_t v, input logic ex);
        send_word(ledger.next_slot(), v, ex);
    endtask

    // hold the sender until every predicted word has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (ledger.pending() != 0) @(negedge aclk);
    endtask

    // register write with the block idle, after any tree build has finished
    task automatic write_runs(input logic [CFG_BITS-1:0] n);
        drain();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        ledger.set_runs(32'(n));
    endtask

    // well-formed load or refill most of the time, a noise word now and then
    task automatic send_random_item();
        leaf_idx_t slot;
        value_t    v;
        logic      ex;
        bit        loading;
        slot    = ledger.next_slot();
        loading = !ledger.merging;
        if ($urandom_range(0, 99) < 8) begin
            ex = 1'($urandom_range(0, 1));
            v  = $urandom;
            send_word(leaf_idx_t'($urandom_range(0, MAX_RUNS - 1)), v, ex);
            if (ex) begin
                run_left[slot] = 0;
            end else begin
                run_tail[slot] = v;
                if (loading) run_left[slot] = $urandom_range(0, 3);
            end
        end else begin
            if (loading) run_left[slot] = pick_len();
            if (run_left[slot] == 0) begin
                ex = 1'b1;
                v  = $urandom;
            end else begin
                ex = 1'b0;
                v  = loading ? pick_head() : climb(run_tail[slot]);
                run_tail[slot] = v;
                run_left[slot]--;
            end
            send_word(slot, v, ex);
        end
    endtask

    // result side back-pressure
    initial begin
        int unsigned hold;
        m_ready = 1'b0;
        hold    = 0;
        forever begin
            @(negedge aclk);
            if (hold != 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    // result check and stall watchdog
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            ledger.match_word(m_winner_value, m_winner_run, m_merge_done);
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned sent;
        int unsigned burst;
        ledger          = new();
        calm            = 1'b0;
        aresetn         = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        s_valid         = 1'b0;
        s_run_index     = '0;
        s_value         = '0;
        s_run_exhausted = 1'b0;
        foreach (run_left[i]) begin
            run_left[i] = 0;
            run_tail[i] = '0;
        end
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // full tree at the reset run count: extremes, ties, empty runs
        push_head(VAL_MAX, 1'b0);
        push_head(5, 1'b0);
        push_head(VAL_MIN, 1'b1);
        push_head(5, 1'b0);
        push_head(VAL_MIN, 1'b0);
        push_head(-1, 1'b0);
        push_head(0, 1'b0);
        push_head(VAL_MAX, 1'b0);
        push_head(32'sh12345678, 1'b1);
        push_head(100, 1'b0);
        push_head(-100, 1'b0);
        push_head(VAL_MIN, 1'b0);
        push_head(7, 1'b0);
        push_head(-1, 1'b1);
        push_head(0, 1'b0);
        push_head(VAL_MAX, 1'b0);
        // exhaust the winner, then refill the next one with a misleading run index
        push_head(0, 1'b1);
        send_word(leaf_idx_t'(MAX_RUNS - 1), VAL_MAX, 1'b0);

        // single run: empty at load, then a max value followed by exhaustion
        write_runs(CFG_BITS'(1));
        push_head(-1, 1'b1);
        push_head(VAL_MAX, 1'b0);
        push_head(0, 1'b1);

        // zero acts as one run; the next write aborts a merge, the one after a partial load
        write_runs(CFG_BITS'(0));
        push_head(3, 1'b0);
        write_runs(CFG_BITS'(2));
        push_head(9, 1'b0);
        write_runs(CFG_BITS'(31));

        // random merges across run counts, each phase ending wherever it lands
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            calm = ($urandom_range(0, 4) == 0);
            write_runs(pick_runs());
            burst = $urandom_range(20, 80);
            for (int k = 0; k < int'(burst); k++) begin
                send_random_item();
                sent++;
                if ($urandom_range(0, 99) == 0) drain();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (ledger.mismatches == 0 && ledger.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
